>>> hdl/tpd_pkg.sv
// Shared types, codes and constant tables for the traffic permutation destination unit.
package tpd_pkg;

   localparam int NODE_W   = 10;
   localparam int STATUS_W = 2;
   localparam int MODE_W   = 3;
   localparam int NBITS_W  = 4;
   localparam int RK_W     = 6;
   localparam int RX_W     = 3;
   localparam int COUNT_W  = 4;
   localparam int RADIX_W  = 9;
   localparam int RECIP_W  = 17;
   localparam int PROD_W   = 26;
   localparam int OFF_W    = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 6;

   // Fixed point position of the reciprocal multiply.
   localparam int RECIP_SHIFT = 16;

   localparam logic [MODE_W-1:0] MODE_COMPLEMENT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TRANSPOSE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SHUFFLE    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TORNADO    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_NEIGHBOR   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CONFIG = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_BITS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX_K      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX_X      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT_COUNT  = 3'd4;

   // ceil(2^16 / d); exact floor division of any 10-bit value by d after a
   // multiply and a shift by 16. Entry zero is never used in a good setup.
   localparam logic [RECIP_W-1:0] RECIP_TABLE [64] = '{
      17'd0,     17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd10923, 17'd9363,
      17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,  17'd4682,  17'd4370,
      17'd4096,  17'd3856,  17'd3641,  17'd3450,  17'd3277,  17'd3121,  17'd2979,  17'd2850,
      17'd2731,  17'd2622,  17'd2521,  17'd2428,  17'd2341,  17'd2260,  17'd2185,  17'd2115,
      17'd2048,  17'd1986,  17'd1928,  17'd1873,  17'd1821,  17'd1772,  17'd1725,  17'd1681,
      17'd1639,  17'd1599,  17'd1561,  17'd1525,  17'd1490,  17'd1457,  17'd1425,  17'd1395,
      17'd1366,  17'd1338,  17'd1311,  17'd1286,  17'd1261,  17'd1237,  17'd1214,  17'd1192,
      17'd1171,  17'd1150,  17'd1130,  17'd1111,  17'd1093,  17'd1075,  17'd1058,  17'd1041
   };

   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic [RADIX_W-1:0] add;
      logic [RECIP_W-1:0] recip_k;
      logic [RECIP_W-1:0] recip_x;
      logic [OFF_W-1:0]   limit;
      logic [COUNT_W-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic [NODE_W-1:0]   src;
      logic [NODE_W-1:0]   bit_dest;
      logic [STATUS_W-1:0] bit_st;
      logic [NODE_W-1:0]   rest;
      logic [NODE_W-1:0]   quo;
      logic [PROD_W-1:0]   prod;
      logic [NODE_W-1:0]   qr;
      logic [OFF_W-1:0]    off;
      logic                sat;
      logic [NODE_W-1:0]   sumoff;
      logic [NODE_W-1:0]   wrapsum;
      logic                pend;
   } pipe_type;

   typedef struct packed {
      logic [NODE_W-1:0]   src;
      logic [NODE_W-1:0]   bit_dest;
      logic [STATUS_W-1:0] bit_st;
      logic [NODE_W-1:0]   addprod;
      logic [NODE_W-1:0]   wrapsum;
      logic [STATUS_W-1:0] dig_st;
   } fin_type;

   // Closes out a digit whose quotient is known. The new digit is
   // digit + add, less the radix when it wraps; a wrap takes one unit of the
   // next digit weight off the result, so only the wrap weights are summed.
   function automatic pipe_type finish_digit(pipe_type p, cfg_type c);
      pipe_type r;
      logic [NODE_W-1:0] digit;
      logic [NODE_W-1:0] sum;
      r = p;
      digit = p.rest - p.qr;
      sum = digit + {1'b0, c.add};
      if (p.pend) begin
         if (sum >= {1'b0, c.radix}) begin
            r.wrapsum = p.wrapsum + p.off[NODE_W-1:0];
         end
         r.pend = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> hdl/traffic_permutation_dest_unit.sv
// Top level of the synthetic traffic destination unit: config, pipeline and output buffering.
//
// Each transaction on the req_ channel carries one source node number; the
// unit returns exactly one transaction on the rsp_ channel with the
// destination node and a status, in order. The pattern and its sizes come
// from five registers written through the csr_ port, which is always ready.
// Registers must be changed only while no transaction is in flight; nothing enforces it.
//
// A transaction passes s0, s1, the digit slices, f1 and the output register
// before rsp_valid. One transaction is accepted every cycle while req_stall
// is low; the rate is set by the fully pipelined datapath, three stages for each
// radix digit, each doing a reciprocal divide by k, then by xr, then a multiply back.
//
// Reset restores the register defaults and empties the pipeline. When the
// receiver stalls, the output register holds its transaction and one more
// result lands in a skid register; req_stall then rises and the whole
// pipeline holds until the skid register drains.
module traffic_permutation_dest_unit #(
   parameter int ADDR_BITS  = 10,
   parameter int MAX_DIGITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tpd_pkg::NODE_W-1:0]          req_source_node,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tpd_pkg::NODE_W-1:0]          rsp_dest_node,
   output logic [tpd_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tpd_pkg::*;

   localparam int BW = (ADDR_BITS > NODE_W) ? ADDR_BITS : NODE_W;
   localparam logic [4:0] BW_L = 5'(BW);
   localparam logic [OFF_W-1:0] LIMIT = {{(OFF_W-1){1'b0}}, 1'b1} << ADDR_BITS;

   // Configuration registers.
   logic [MODE_W-1:0]  pattern_mode_ff;
   logic [NBITS_W-1:0] node_bits_ff;
   logic [RK_W-1:0]    radix_k_ff;
   logic [RX_W-1:0]    radix_x_ff;
   logic [COUNT_W-1:0] digit_count_ff;
   cfg_type            cfg_in, cfg_ff;

   // Pipeline.
   logic               advance;
   logic               s0_valid_ff;
   logic [NODE_W-1:0]  s0_src_ff;
   logic               s1_valid_ff;
   pipe_type           s1_in, s1_ff;
   logic [MAX_DIGITS:0]     chain_valid;
   pipe_type [MAX_DIGITS:0] chain_data;
   logic               f1_valid_ff;
   fin_type            f1_in, f1_ff;
   pipe_type           last_done;
   logic [NODE_W+RADIX_W-1:0] add_prod;

   // Bit pattern datapath.
   logic [BW-1:0]      s_w, mask, lo_mask, rev, bit_res;
   logic [NBITS_W-1:0] half;
   logic [4:0]         rev_shift;
   logic               bit_err;

   // Output side.
   logic [NODE_W-1:0]   new_dest, dig_dest;
   logic [STATUS_W-1:0] new_status;
   logic                rsp_take;
   logic                rsp_valid_in, rsp_valid_ff, skid_valid_in, skid_valid_ff;
   logic [NODE_W-1:0]   rsp_dest_in, rsp_dest_ff, skid_dest_in, skid_dest_ff;
   logic [STATUS_W-1:0] rsp_status_in, rsp_status_ff, skid_status_in, skid_status_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_mode_ff <= MODE_COMPLEMENT;
         node_bits_ff    <= 4'd6;
         radix_k_ff      <= 6'd4;
         radix_x_ff      <= 3'd1;
         digit_count_ff  <= 4'd2;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_MODE: pattern_mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_NODE_BITS:    node_bits_ff    <= csr_wdata[NBITS_W-1:0];
            CSR_RADIX_K:      radix_k_ff      <= csr_wdata[RK_W-1:0];
            CSR_RADIX_X:      radix_x_ff      <= csr_wdata[RX_W-1:0];
            CSR_DIGIT_COUNT:  digit_count_ff  <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Values derived from the registers, held in a register of their own (cfg_ff).
   always_comb begin
      cfg_in.radix   = {3'b000, radix_k_ff} * {6'b000000, radix_x_ff};
      if (pattern_mode_ff == MODE_TORNADO) begin
         cfg_in.add = ((cfg_in.radix + 9'd1) >> 1) - 9'd1;
      end else begin
         cfg_in.add = (cfg_in.radix == 9'd1) ? 9'd0 : 9'd1;
      end
      cfg_in.recip_k = RECIP_TABLE[radix_k_ff];
      cfg_in.recip_x = RECIP_TABLE[{3'b000, radix_x_ff}];
      cfg_in.limit   = LIMIT;
      cfg_in.count   = digit_count_ff;
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign advance   = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage 1: bit patterns in full, and the digit walk is primed.
   always_comb begin
      s_w       = BW'(s0_src_ff);
      mask      = ~({BW{1'b1}} << node_bits_ff);
      half      = node_bits_ff >> 1;
      lo_mask   = ~({BW{1'b1}} << half);
      rev_shift = BW_L - {1'b0, node_bits_ff};
      for (int i = 0; i < BW; i++) begin
         rev[i] = s_w[BW-1-i];
      end
      case (pattern_mode_ff[1:0])
         MODE_COMPLEMENT[1:0]: bit_res = ~s_w & mask;
         MODE_TRANSPOSE[1:0]:  bit_res = ((s_w >> half) & lo_mask)
                                        | ((s_w << half) & (lo_mask << half));
         MODE_REVERSE[1:0]:    bit_res = rev >> rev_shift;
         default:              bit_res = ((s_w << 1) & mask)
                                        | ((s_w >> (node_bits_ff - 4'd1)) & BW'(1));
      endcase
      bit_err = (node_bits_ff == 4'd0) || ({1'b0, node_bits_ff} > 5'(ADDR_BITS))
                || ((pattern_mode_ff == MODE_TRANSPOSE) && node_bits_ff[0]);

      s1_in.src      = s0_src_ff;
      s1_in.bit_dest = bit_res[NODE_W-1:0];
      if (bit_err) begin
         s1_in.bit_st = ST_CONFIG;
      end else if ((s_w >> node_bits_ff) != '0) begin
         s1_in.bit_st = ST_RANGE;
      end else begin
         s1_in.bit_st = ST_OK;
      end
      s1_in.rest    = s0_src_ff;
      s1_in.quo     = s0_src_ff;
      s1_in.prod    = '0;
      s1_in.qr      = '0;
      s1_in.off     = OFF_W'(1);
      s1_in.sat     = 1'b0;
      s1_in.sumoff  = '0;
      s1_in.wrapsum = '0;
      s1_in.pend    = 1'b0;
   end

   assign chain_valid[0] = s1_valid_ff;
   assign chain_data[0]  = s1_ff;

   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digit
      tpd_digit_slice #(
         .SLICE_INDEX (g)
      ) u_slice (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .cfg       (cfg_ff),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // Final stage: retire the last digit and form the offset product.
   always_comb begin
      last_done      = finish_digit(chain_data[MAX_DIGITS], cfg_ff);
      add_prod       = {{NODE_W{1'b0}}, cfg_ff.add} * {{RADIX_W{1'b0}}, last_done.sumoff};
      f1_in.src      = last_done.src;
      f1_in.bit_dest = last_done.bit_dest;
      f1_in.bit_st   = last_done.bit_st;
      f1_in.addprod  = add_prod[NODE_W-1:0];
      f1_in.wrapsum  = last_done.wrapsum;
      if ((cfg_ff.radix == '0) || (cfg_ff.count == '0)
          || ({1'b0, cfg_ff.count} > 5'(MAX_DIGITS)) || last_done.sat) begin
         f1_in.dig_st = ST_CONFIG;
      end else if (last_done.quo != '0) begin
         // A quotient left after the last digit means the source is too large.
         f1_in.dig_st = ST_RANGE;
      end else begin
         f1_in.dig_st = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         f1_valid_ff <= chain_valid[MAX_DIGITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_src_ff <= req_source_node;
         s1_ff     <= s1_in;
         f1_ff     <= f1_in;
      end
   end

   // Result selection; arithmetic modulo 2^10 matches the truncated output.
   always_comb begin
      dig_dest = f1_ff.src + f1_ff.addprod - f1_ff.wrapsum;
      case (pattern_mode_ff)
         MODE_COMPLEMENT, MODE_TRANSPOSE, MODE_REVERSE, MODE_SHUFFLE: begin
            new_status = f1_ff.bit_st;
            new_dest   = f1_ff.bit_dest;
         end
         MODE_TORNADO, MODE_NEIGHBOR: begin
            new_status = f1_ff.dig_st;
            new_dest   = dig_dest;
         end
         default: begin
            new_status = ST_CONFIG;
            new_dest   = '0;
         end
      endcase
      if (new_status != ST_OK) begin
         new_dest = '0;
      end
   end

   assign rsp_take = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_dest_in    = rsp_dest_ff;
      rsp_status_in  = rsp_status_ff;
      skid_valid_in  = skid_valid_ff;
      skid_dest_in   = skid_dest_ff;
      skid_status_in = skid_status_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_dest_in   = skid_dest_ff;
            rsp_status_in = skid_status_ff;
            skid_valid_in = 1'b0;
         end
      end else if (f1_valid_ff) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in  = 1'b1;
            rsp_dest_in   = new_dest;
            rsp_status_in = new_status;
         end else begin
            skid_valid_in  = 1'b1;
            skid_dest_in   = new_dest;
            skid_status_in = new_status;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dest_ff    <= rsp_dest_in;
      rsp_status_ff  <= rsp_status_in;
      skid_dest_ff   <= skid_dest_in;
      skid_status_ff <= skid_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dest_node = rsp_dest_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

>>> hdl/tpd_digit_slice.sv
// One radix digit of the digit patterns: three pipeline stages around two reciprocal multiplies.
module tpd_digit_slice #(
   parameter int SLICE_INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  tpd_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  tpd_pkg::pipe_type in_data,
   output logic              out_valid,
   output tpd_pkg::pipe_type out_data
);
   import tpd_pkg::*;

   logic     active;
   pipe_type done;
   pipe_type a_in, a_ff, b_in, b_ff, c_in, c_ff;
   logic     a_valid_ff, b_valid_ff, c_valid_ff;
   logic [RADIX_W+OFF_W-1:0]  off_prod;
   logic [NODE_W+RECIP_W-1:0] div_prod;
   logic [NODE_W+RECIP_W-1:0] div_prod2;
   logic [NODE_W+RADIX_W-1:0] back_prod;

   assign active = cfg.count > COUNT_W'(SLICE_INDEX);

   // Stage A: retire the previous digit; when active, divide by k and advance the weight.
   always_comb begin
      done     = finish_digit(in_data, cfg);
      a_in     = done;
      off_prod = {{RADIX_W{1'b0}}, done.off} * {{OFF_W{1'b0}}, cfg.radix};
      div_prod = {{RECIP_W{1'b0}}, done.quo} * {{NODE_W{1'b0}}, cfg.recip_k};
      if (active) begin
         a_in.rest   = done.quo;
         a_in.prod   = div_prod[PROD_W-1:0];
         a_in.sumoff = done.sumoff + done.off[NODE_W-1:0];
         a_in.sat    = done.sat | (off_prod > {{RADIX_W{1'b0}}, cfg.limit});
         a_in.off    = off_prod[OFF_W-1:0];
      end
   end

   // Stage B: when active, divide the partial quotient by the concentration factor.
   always_comb begin
      b_in      = a_ff;
      div_prod2 = {{RECIP_W{1'b0}}, a_ff.prod[PROD_W-1:RECIP_SHIFT]}
                  * {{NODE_W{1'b0}}, cfg.recip_x};
      if (active) begin
         b_in.prod = div_prod2[PROD_W-1:0];
      end
   end

   // Stage C: when active, the quotient times the radix gives back the digit.
   always_comb begin
      c_in      = b_ff;
      back_prod = {{RADIX_W{1'b0}}, b_ff.prod[PROD_W-1:RECIP_SHIFT]}
                  * {{NODE_W{1'b0}}, cfg.radix};
      if (active) begin
         c_in.quo  = b_ff.prod[PROD_W-1:RECIP_SHIFT];
         c_in.qr   = back_prod[NODE_W-1:0];
         c_in.pend = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_ff;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the traffic permutation destination unit.
`timescale 1ns / 100ps

module testbench;
   import tpd_pkg::*;

   localparam int ADDR_BITS       = 10;
   localparam int MAX_DIGITS      = 10;
   localparam int RAND_PHASES     = 16;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int PIPE_LATENCY    = 3 * MAX_DIGITS + 3;
   localparam int ROUTE_DEPTH     = 1024;

   // Mode codes that the unit must reject as a bad configuration.
   localparam logic [MODE_W-1:0] MODE_RESERVED_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RESERVED_7 = 3'd7;

   typedef struct packed {
      logic [NODE_W-1:0]   dest;
      logic [STATUS_W-1:0] status;
   } route_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [NBITS_W-1:0]  nbits;
      logic [RK_W-1:0]     rk;
      logic [RX_W-1:0]     rx;
      logic [COUNT_W-1:0]  count;
      logic [NODE_W-1:0]   src;
      logic                fixed;
      logic [NODE_W-1:0]   dest;
      logic [STATUS_W-1:0] status;
   } dir_row_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [NODE_W-1:0]      req_source_node = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [NODE_W-1:0]      rsp_dest_node;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Typed-in expectation that travels with the source node of a directed row.
   logic                   req_fixed = 1'b0;
   logic [NODE_W-1:0]      fixed_dest = '0;
   logic [STATUS_W-1:0]    fixed_status = '0;

   // Local copy of the registers, starting from their reset values.
   logic [MODE_W-1:0]      cfg_mode  = MODE_COMPLEMENT;
   logic [NBITS_W-1:0]     cfg_nbits = 4'd6;
   logic [RK_W-1:0]        cfg_rk    = 6'd4;
   logic [RX_W-1:0]        cfg_rx    = 3'd1;
   logic [COUNT_W-1:0]     cfg_count = 4'd2;

   // Expected results in order, as a ring indexed by running counts.
   route_type pending_routes [ROUTE_DEPTH];
   int     route_wr = 0;
   int     route_rd = 0;
   logic   quiet = 1'b0;
   int     stall_left = 0;
   int     cycles = 0;
   int     mismatches = 0;
   int     accepted = 0;
   int     delivered = 0;
   int     settings = 0;
   int     config_errors = 0;
   int     range_errors = 0;

   dir_row_type dir_rows [26];

   traffic_permutation_dest_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_source_node (req_source_node),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dest_node   (rsp_dest_node),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Number of legal source nodes under the current setting, or zero when the
   // setting itself is bad.
   function automatic int node_range();
      int r;
      int span;
      int i;
      if (cfg_mode <= MODE_SHUFFLE) begin
         if (cfg_nbits == 0 || cfg_nbits > ADDR_BITS ||
             (cfg_mode == MODE_TRANSPOSE && cfg_nbits[0]))
            return 0;
         return 1 << cfg_nbits;
      end
      if (cfg_mode > MODE_NEIGHBOR)
         return 0;
      r = int'(cfg_rk) * int'(cfg_rx);
      if (r == 0 || cfg_count == 0 || cfg_count > MAX_DIGITS)
         return 0;
      span = 1;
      for (i = 0; i < cfg_count; i++) begin
         span = span * r;
         if (span > (1 << ADDR_BITS))
            return 0;
      end
      return span;
   endfunction

   function automatic route_type route_dest(logic [NODE_W-1:0] src);
      route_type res;
      int span;
      int s;
      int nb;
      int h;
      int lo;
      int r;
      int add;
      int rest;
      int off;
      int acc;
      int i;
      res = '0;
      span = node_range();
      s = int'(src);
      nb = int'(cfg_nbits);
      acc = 0;
      if (span == 0) begin
         res.status = ST_CONFIG;
      end else if (s >= span) begin
         res.status = ST_RANGE;
      end else begin
         res.status = ST_OK;
         case (cfg_mode)
            MODE_COMPLEMENT: begin
               acc = ~s & (span - 1);
            end
            MODE_TRANSPOSE: begin
               h = nb / 2;
               lo = (1 << h) - 1;
               acc = ((s >> h) & lo) | ((s << h) & (lo << h));
            end
            MODE_REVERSE: begin
               for (i = 0; i < nb; i++)
                  acc = (acc << 1) | ((s >> i) & 1);
            end
            MODE_SHUFFLE: begin
               acc = ((s << 1) & (span - 1)) | ((s >> (nb - 1)) & 1);
            end
            default: begin
               // Every digit moves on its own, with no carry into the next.
               r = int'(cfg_rk) * int'(cfg_rx);
               add = (cfg_mode == MODE_TORNADO) ? (r + 1) / 2 - 1 : 1 % r;
               rest = s;
               off = 1;
               for (i = 0; i < cfg_count; i++) begin
                  acc = acc + off * (((rest % r) + add) % r);
                  rest = rest / r;
                  off = off * r;
               end
            end
         endcase
      end
      res.dest = acc[NODE_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int expv, input int gotv);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s of result %0d: expected %0d, got %0d",
                  what, delivered, expv, gotv);
   endtask

   // Input acceptance and result checking share one block so that the
   // expectation is always queued before it could be looked for.
   always @(posedge clock) begin
      route_type exp_route;
      route_type new_route;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_fixed) begin
               new_route.dest   = fixed_dest;
               new_route.status = fixed_status;
            end else begin
               new_route = route_dest(req_source_node);
            end
            pending_routes[route_wr % ROUTE_DEPTH] = new_route;
            route_wr++;
            accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (route_wr == route_rd) begin
               report_mismatch("unexpected transaction, dest", -1, rsp_dest_node);
            end else begin
               exp_route = pending_routes[route_rd % ROUTE_DEPTH];
               route_rd++;
               if (rsp_dest_node !== exp_route.dest)
                  report_mismatch("dest_node", exp_route.dest, rsp_dest_node);
               if (rsp_status !== exp_route.status)
                  report_mismatch("status", exp_route.status, rsp_status);
            end
            if (rsp_status == ST_CONFIG)
               config_errors++;
            if (rsp_status == ST_RANGE)
               range_errors++;
            delivered++;
         end
      end
   end

   // Receiver back-pressure: bursts of stall separated by runs of free flow.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (!rsp_stall && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(0, 40);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results pending",
                  cycles, route_wr - route_rd);
         $display("** traffic_permutation_dest_unit: FAILED **");
         $finish;
      end
   end

   task automatic send_source(input logic [NODE_W-1:0] src, input logic fixed,
                              input logic [NODE_W-1:0] dest,
                              input logic [STATUS_W-1:0] status);
      req_valid       <= 1'b1;
      req_source_node <= src;
      req_fixed       <= fixed;
      fixed_dest      <= dest;
      fixed_status    <= status;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13))
            @(posedge clock);
      end
   endtask

   // Stops the sender and waits until every queued result has come back.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (route_wr != route_rd)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_PATTERN_MODE: cfg_mode  = data[MODE_W-1:0];
         CSR_NODE_BITS:    cfg_nbits = data[NBITS_W-1:0];
         CSR_RADIX_K:      cfg_rk    = data[RK_W-1:0];
         CSR_RADIX_X:      cfg_rx    = data[RX_W-1:0];
         CSR_DIGIT_COUNT:  cfg_count = data[COUNT_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      dir_row_type row;
      logic [MODE_W-1:0]     mode;
      logic [NBITS_W-1:0]    nbits;
      logic [RK_W-1:0]       rk;
      logic [RX_W-1:0]       rx;
      logic [COUNT_W-1:0]    count;
      logic [CSR_DATA_W-1:0] data;
      int phase;
      int i;
      int span;
      int max_count;
      int r;
      logic [NODE_W-1:0] src;

      dir_rows = '{
         '{MODE_COMPLEMENT, 4'd6,  6'd4,  3'd1, 4'd2,  10'd0,    1'b1, 10'd63,  ST_OK},
         '{MODE_COMPLEMENT, 4'd6,  6'd4,  3'd1, 4'd2,  10'd63,   1'b1, 10'd0,   ST_OK},
         '{MODE_COMPLEMENT, 4'd6,  6'd4,  3'd1, 4'd2,  10'd64,   1'b1, 10'd0,   ST_RANGE},
         '{MODE_COMPLEMENT, 4'd6,  6'd4,  3'd1, 4'd2,  10'd1023, 1'b1, 10'd0,   ST_RANGE},
         '{MODE_COMPLEMENT, 4'd10, 6'd4,  3'd1, 4'd2,  10'd0,    1'b1, 10'd1023, ST_OK},
         '{MODE_COMPLEMENT, 4'd0,  6'd4,  3'd1, 4'd2,  10'd0,    1'b1, 10'd0,   ST_CONFIG},
         '{MODE_COMPLEMENT, 4'd15, 6'd4,  3'd1, 4'd2,  10'd5,    1'b1, 10'd0,   ST_CONFIG},
         '{MODE_TRANSPOSE,  4'd10, 6'd4,  3'd1, 4'd2,  10'd31,   1'b0, 10'd0,   ST_OK},
         '{MODE_TRANSPOSE,  4'd9,  6'd4,  3'd1, 4'd2,  10'd3,    1'b1, 10'd0,   ST_CONFIG},
         '{MODE_TRANSPOSE,  4'd2,  6'd4,  3'd1, 4'd2,  10'd2,    1'b0, 10'd0,   ST_OK},
         '{MODE_REVERSE,    4'd10, 6'd4,  3'd1, 4'd2,  10'd1,    1'b1, 10'd512, ST_OK},
         '{MODE_REVERSE,    4'd10, 6'd4,  3'd1, 4'd2,  10'd1023, 1'b1, 10'd1023, ST_OK},
         '{MODE_SHUFFLE,    4'd10, 6'd4,  3'd1, 4'd2,  10'd512,  1'b1, 10'd1,   ST_OK},
         '{MODE_SHUFFLE,    4'd1,  6'd4,  3'd1, 4'd2,  10'd1,    1'b0, 10'd0,   ST_OK},
         '{MODE_RESERVED_6, 4'd6,  6'd4,  3'd1, 4'd2,  10'd0,    1'b1, 10'd0,   ST_CONFIG},
         '{MODE_RESERVED_7, 4'd6,  6'd4,  3'd1, 4'd2,  10'd1023, 1'b1, 10'd0,   ST_CONFIG},
         '{MODE_TORNADO,    4'd6,  6'd4,  3'd1, 4'd2,  10'd15,   1'b0, 10'd0,   ST_OK},
         '{MODE_TORNADO,    4'd6,  6'd32, 3'd1, 4'd2,  10'd1023, 1'b0, 10'd0,   ST_OK},
         '{MODE_NEIGHBOR,   4'd6,  6'd32, 3'd4, 4'd1,  10'd127,  1'b0, 10'd0,   ST_OK},
         '{MODE_NEIGHBOR,   4'd6,  6'd1,  3'd1, 4'd10, 10'd0,    1'b1, 10'd0,   ST_OK},
         '{MODE_NEIGHBOR,   4'd6,  6'd1,  3'd1, 4'd10, 10'd1,    1'b1, 10'd0,   ST_RANGE},
         '{MODE_TORNADO,    4'd6,  6'd0,  3'd1, 4'd2,  10'd0,    1'b1, 10'd0,   ST_CONFIG},
         '{MODE_TORNADO,    4'd6,  6'd4,  3'd0, 4'd2,  10'd0,    1'b1, 10'd0,   ST_CONFIG},
         '{MODE_NEIGHBOR,   4'd6,  6'd4,  3'd1, 4'd15, 10'd0,    1'b1, 10'd0,   ST_CONFIG},
         '{MODE_TORNADO,    4'd6,  6'd32, 3'd4, 4'd2,  10'd0,    1'b1, 10'd0,   ST_CONFIG},
         '{MODE_NEIGHBOR,   4'd6,  6'd2,  3'd1, 4'd10, 10'd1023, 1'b0, 10'd0,   ST_OK}
      };

      repeat (2)
         @(posedge clock);
      reset <= 1'b0;

      // Directed rows: registers change only when a row asks for a new value.
      for (i = 0; i < $size(dir_rows); i++) begin
         row = dir_rows[i];
         if (row.mode != cfg_mode || row.nbits != cfg_nbits || row.rk != cfg_rk ||
             row.rx != cfg_rx || row.count != cfg_count) begin
            drain_pipe();
            if (row.mode != cfg_mode)
               write_reg(CSR_PATTERN_MODE, CSR_DATA_W'(row.mode));
            if (row.nbits != cfg_nbits)
               write_reg(CSR_NODE_BITS, CSR_DATA_W'(row.nbits));
            if (row.rk != cfg_rk)
               write_reg(CSR_RADIX_K, CSR_DATA_W'(row.rk));
            if (row.rx != cfg_rx)
               write_reg(CSR_RADIX_X, CSR_DATA_W'(row.rx));
            if (row.count != cfg_count)
               write_reg(CSR_DIGIT_COUNT, CSR_DATA_W'(row.count));
            settings++;
         end
         send_source(row.src, row.fixed, row.dest, row.status);
      end

      // Random phases: a fresh setting each time, mostly legal, with the upper
      // bits of every register write scrambled since the unit ignores them.
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         drain_pipe();
         if (phase == RAND_PHASES - 1)
            quiet <= 1'b1;

         if ($urandom_range(0, 9) == 0)
            mode = $urandom_range(0, 1) ? MODE_RESERVED_6 : MODE_RESERVED_7;
         else
            mode = MODE_W'($urandom_range(0, 5));

         case ($urandom_range(0, 9))
            0:       nbits = $urandom_range(0, 1) ? 4'd0 : NBITS_W'($urandom_range(11, 15));
            1:       nbits = 4'd10;
            2:       nbits = 4'd1;
            default: nbits = NBITS_W'($urandom_range(1, 10));
         endcase
         if (mode == MODE_TRANSPOSE && $urandom_range(0, 3) != 0)
            nbits = NBITS_W'(2 * $urandom_range(1, 5));

         case ($urandom_range(0, 9))
            0:       rk = $urandom_range(0, 1) ? 6'd0 : RK_W'($urandom_range(33, 63));
            1:       rk = 6'd32;
            2:       rk = 6'd1;
            default: rk = RK_W'($urandom_range(1, 32));
         endcase
         if ($urandom_range(0, 9) == 0)
            rx = $urandom_range(0, 1) ? 3'd0 : RX_W'($urandom_range(5, 7));
         else
            rx = RX_W'($urandom_range(1, 4));

         // Largest digit count whose node range still fits the address width.
         r = int'(rk) * int'(rx);
         max_count = 0;
         if (r == 1) begin
            max_count = MAX_DIGITS;
         end else if (r > 1) begin
            span = r;
            while (span <= (1 << ADDR_BITS) && max_count < MAX_DIGITS) begin
               max_count++;
               span = span * r;
            end
         end
         case ($urandom_range(0, 9))
            0:       count = $urandom_range(0, 1) ? 4'd0 : COUNT_W'($urandom_range(11, 15));
            1:       count = COUNT_W'(max_count + 1);
            2:       count = COUNT_W'(max_count);
            default: count = (max_count > 0) ? COUNT_W'($urandom_range(1, max_count)) : 4'd1;
         endcase

         data = CSR_DATA_W'($urandom);
         data[MODE_W-1:0] = mode;
         write_reg(CSR_PATTERN_MODE, data);
         data = CSR_DATA_W'($urandom);
         data[NBITS_W-1:0] = nbits;
         write_reg(CSR_NODE_BITS, data);
         write_reg(CSR_RADIX_K, rk);
         data = CSR_DATA_W'($urandom);
         data[RX_W-1:0] = rx;
         write_reg(CSR_RADIX_X, data);
         data = CSR_DATA_W'($urandom);
         data[COUNT_W-1:0] = count;
         write_reg(CSR_DIGIT_COUNT, data);
         settings++;

         span = node_range();
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (span == 0 || $urandom_range(0, 7) == 0)
               src = NODE_W'($urandom_range(0, 1023));
            else if ($urandom_range(0, 9) == 0)
               src = $urandom_range(0, 1) ? NODE_W'(span - 1) : '0;
            else
               src = NODE_W'($urandom_range(0, span - 1));
            send_source(src, 1'b0, '0, ST_OK);
         end
      end

      drain_pipe();
      repeat (PIPE_LATENCY + 8)
         @(posedge clock);

      $display("Mapped %0d source nodes under %0d register settings across all six patterns;",
               accepted, settings);
      $display("%0d results reported a bad setting and %0d an out-of-range source.",
               config_errors, range_errors);
      if (mismatches == 0 && route_wr == route_rd) begin
         $display("** traffic_permutation_dest_unit: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches,
                  route_wr - route_rd);
         $display("** traffic_permutation_dest_unit: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/tpd_pkg.sv
hdl/tpd_digit_slice.sv
hdl/traffic_permutation_dest_unit.sv
test/testbench.sv
